// ----- rtl/blob_extent_accumulator_defines.svh -----
// Assertion macros shared by the blob extent accumulator RTL.
`ifndef BLOB_EXTENT_ACCUMULATOR_DEFINES_SVH
`define BLOB_EXTENT_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BEA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BEA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/bea_pkg.sv -----
// Types, codes and sizes shared by the blob extent accumulator modules.
`default_nettype none

package bea_pkg;

    localparam int COORD_BITS  = 10;
    localparam int COUNT_BITS  = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int OBUF_DEPTH  = 2;
    localparam int OPTR_BITS   = $clog2(OBUF_DEPTH);
    localparam int OCNT_BITS   = $clog2(OBUF_DEPTH + 1);

    localparam logic [1:0] FUNC_PIXEL    = 2'd0;
    localparam logic [1:0] FUNC_RECEPTOR = 2'd1;
    localparam logic [1:0] FUNC_MERGE    = 2'd2;

    localparam logic [1:0] CFG_IDX_RECEPTOR = 2'd0;
    localparam logic [1:0] CFG_IDX_WRAP_POS = 2'd1;
    localparam logic [1:0] CFG_IDX_WRAP_NEG = 2'd2;

    localparam int OTHER_VALID_BIT = 0;
    localparam int OTHER_CROWN_BIT = 1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PIXEL,
        OP_RECEPTOR,
        OP_MERGE
    } t_op;

    typedef struct packed {
        logic        [1:0]            func;
        logic        [COORD_BITS-1:0] x_low;
        logic        [COORD_BITS-1:0] x_high;
        logic        [COORD_BITS-1:0] y_low;
        logic        [COORD_BITS-1:0] y_high;
        logic        [15:0]           rho_low;
        logic        [15:0]           rho_high;
        logic signed [15:0]           theta_low;
        logic signed [15:0]           theta_high;
        logic        [COUNT_BITS-1:0] other_receptors;
        logic        [COUNT_BITS-1:0] other_pixels;
        logic        [1:0]            other_flags;
    } t_item;

    typedef struct packed {
        logic                         absorbed;
        logic        [COUNT_BITS-1:0] pixel_count;
        logic        [COUNT_BITS-1:0] receptor_count;
        logic        [COORD_BITS-1:0] box_min_x;
        logic        [COORD_BITS-1:0] box_max_x;
        logic        [COORD_BITS-1:0] box_min_y;
        logic        [COORD_BITS-1:0] box_max_y;
        logic        [15:0]           range_min_rho;
        logic        [15:0]           range_max_rho;
        logic signed [15:0]           range_min_theta;
        logic signed [15:0]           range_max_theta;
        logic                         crown_flag;
    } t_result;

    typedef struct packed {
        t_op   op;
        t_item item;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/bea_queue.sv -----
// Short command queue between the classifying front and the update back end.
`default_nettype none

`include "blob_extent_accumulator_defines.svh"

module bea_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire bea_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output bea_pkg::t_cmd      o_cmd
);
    import bea_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr;
    logic [QPTR_BITS-1:0] r_rptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 push_fire;
    logic                 pop_fire;

    assign o_ready   = r_count < QCNT_BITS'(QUEUE_DEPTH);
    assign o_valid   = r_count != '0;
    assign o_cmd     = r_mem[r_rptr];
    assign push_fire = i_valid && o_ready;
    assign pop_fire  = i_ready && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_fire) begin
                r_wptr <= r_wptr + QPTR_BITS'(1);
            end
            if (pop_fire) begin
                r_rptr <= r_rptr + QPTR_BITS'(1);
            end
            if (push_fire && !pop_fire) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (pop_fire && !push_fire) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

    `BEA_ASSERT_NEXT(a_q_drain, i_clk, i_rst_n, pop_fire && !push_fire,
                     r_count == $past(r_count) - QCNT_BITS'(1))
    `BEA_ASSERT_NEXT(a_q_fill, i_clk, i_rst_n, push_fire && !pop_fire,
                     r_count == $past(r_count) + QCNT_BITS'(1))

endmodule

`default_nettype wire

// ----- rtl/bea_front.sv -----
// Input stage: takes transactions and classifies them into update commands.
`default_nettype none

module bea_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire bea_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output bea_pkg::t_cmd       o_cmd
);
    import bea_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_op  op;
    logic accept;

    always_comb begin
        unique case (i_item.func)
            FUNC_PIXEL:    op = OP_PIXEL;
            FUNC_RECEPTOR: op = OP_RECEPTOR;
            FUNC_MERGE:    op = i_item.other_flags[OTHER_VALID_BIT] ? OP_MERGE : OP_NONE;
            default:       op = OP_NONE;
        endcase
    end

    assign full    = r_valid && !i_ready;
    assign accept  = push && !full;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op   <= op;
            r_cmd.item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bea_back.sv -----
// Blob state, configuration registers, update logic and result buffer.
`default_nettype none

`include "blob_extent_accumulator_defines.svh"

module bea_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire bea_pkg::t_cmd i_cmd,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [16:0]   i_cfg_data,
    output logic               empty,
    input  wire logic          pop,
    output bea_pkg::t_result   o_result
);
    import bea_pkg::*;

    typedef struct packed {
        logic signed [15:0] lo;
        logic signed [15:0] hi;
    } t_theta_pair;

    logic                     r_cfg_recv;
    logic signed [16:0]       r_cfg_pos;
    logic signed [16:0]       r_cfg_neg;

    logic [COUNT_BITS-1:0]    r_pix_total, n_pix_total;
    logic [COUNT_BITS-1:0]    r_rec_total, n_rec_total;
    logic [COORD_BITS-1:0]    r_lo_x, n_lo_x, r_hi_x, n_hi_x;
    logic [COORD_BITS-1:0]    r_lo_y, n_lo_y, r_hi_y, n_hi_y;
    logic [15:0]              r_lo_rho, n_lo_rho, r_hi_rho, n_hi_rho;
    logic signed [15:0]       r_lo_theta, n_lo_theta, r_hi_theta, n_hi_theta;
    logic                     r_crown, n_crown;
    logic                     r_alive;
    logic                     n_absorbed;

    t_result                  r_obuf [OBUF_DEPTH];
    logic [OPTR_BITS-1:0]     r_owp, r_orp;
    logic [OCNT_BITS-1:0]     r_ocnt;
    logic                     cmd_fire;
    logic                     pop_fire;
    t_result                  res;
    t_theta_pair              th_rec, th_merge;
    logic                     merge_ok;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic signed [16:0] tdiff(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        return $signed({a[15], a}) - $signed({b[15], b});
    endfunction

    function automatic logic [16:0] mag(input logic signed [16:0] v);
        return v[16] ? 17'(-v) : 17'(v);
    endfunction

    function automatic t_theta_pair add_receptor(input logic signed [15:0] lo,
                                                 input logic signed [15:0] hi,
                                                 input logic signed [15:0] t,
                                                 input logic signed [16:0] pos,
                                                 input logic signed [16:0] neg);
        t_theta_pair        r;
        logic signed [16:0] d_lo;
        logic signed [16:0] d_hi;
        d_lo = tdiff(lo, t);
        d_hi = tdiff(hi, t);
        r.lo = lo;
        r.hi = hi;
        if (lo > hi) begin
            if (mag(d_lo) < mag(d_hi)) begin
                if (lo > t) r.lo = t;
            end else begin
                if (hi < t) r.hi = t;
            end
        end else if (d_hi > pos || d_lo > pos) begin
            r.hi = t;
        end else if (d_hi < neg || d_lo < neg) begin
            r.lo = t;
        end else begin
            if (lo > t) r.lo = t;
            if (hi < t) r.hi = t;
        end
        return r;
    endfunction

    function automatic t_theta_pair merge_theta(input logic signed [15:0] lo,
                                                input logic signed [15:0] hi,
                                                input logic signed [15:0] bmin,
                                                input logic signed [15:0] bmax,
                                                input logic signed [16:0] pos,
                                                input logic signed [16:0] neg);
        t_theta_pair        r;
        logic               sw;
        logic               ow;
        logic signed [16:0] d_lmin;
        logic signed [16:0] d_hmax;
        logic signed [16:0] d_lmax;
        sw     = lo > hi;
        ow     = bmin > bmax;
        d_lmin = tdiff(lo, bmin);
        d_hmax = tdiff(hi, bmax);
        d_lmax = tdiff(lo, bmax);
        r.lo   = lo;
        r.hi   = hi;
        if (sw && ow) begin
            if (lo > bmin) r.lo = bmin;
            if (hi < bmax) r.hi = bmax;
        end else if (sw) begin
            if (d_lmin > pos) begin
                if (hi < bmax) r.hi = bmax;
            end else if (d_hmax < neg) begin
                if (lo > bmin) r.lo = bmin;
            end else begin
                if (lo > bmin) r.lo = bmin;
                if (hi < bmax) r.hi = bmax;
            end
        end else if (ow) begin
            if (d_lmin < neg) begin
                if (lo < bmin) r.lo = bmin;
                if (hi < bmax) r.hi = bmax;
            end else if (d_hmax > pos) begin
                if (lo > bmin) r.lo = bmin;
                if (hi > bmax) r.hi = bmax;
            end else begin
                if (lo > bmin) r.lo = bmin;
                if (hi < bmax) r.hi = bmax;
            end
        end else if (d_hmax > pos || d_lmin > pos) begin
            r.hi = bmax;
        end else if (d_hmax < neg || d_lmax < neg) begin
            r.lo = bmin;
        end else begin
            if (lo > bmin) r.lo = bmin;
            if (hi < bmax) r.hi = bmax;
        end
        return r;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_ready     = r_ocnt != OCNT_BITS'(OBUF_DEPTH);
    assign cmd_fire    = i_valid && o_ready;
    assign empty       = r_ocnt == '0;
    assign pop_fire    = pop && !empty;
    assign o_result    = r_obuf[r_orp];
    assign merge_ok    = r_alive && i_cmd.item.other_flags[OTHER_VALID_BIT];

    assign th_rec   = add_receptor(r_lo_theta, r_hi_theta, i_cmd.item.theta_low,
                                   r_cfg_pos, r_cfg_neg);
    assign th_merge = merge_theta(r_lo_theta, r_hi_theta, i_cmd.item.theta_low,
                                  i_cmd.item.theta_high, r_cfg_pos, r_cfg_neg);

    always_comb begin
        n_pix_total = r_pix_total;
        n_rec_total = r_rec_total;
        n_lo_x      = r_lo_x;
        n_hi_x      = r_hi_x;
        n_lo_y      = r_lo_y;
        n_hi_y      = r_hi_y;
        n_lo_rho    = r_lo_rho;
        n_hi_rho    = r_hi_rho;
        n_lo_theta  = r_lo_theta;
        n_hi_theta  = r_hi_theta;
        n_crown     = r_crown;
        n_absorbed  = 1'b0;
        unique case (i_cmd.op)
            OP_PIXEL: begin
                n_pix_total = sat_add(r_pix_total, COUNT_BITS'(1));
                if (r_lo_x > i_cmd.item.x_low) n_lo_x = i_cmd.item.x_low;
                if (r_hi_x < i_cmd.item.x_low) n_hi_x = i_cmd.item.x_low;
                if (r_lo_y > i_cmd.item.y_low) n_lo_y = i_cmd.item.y_low;
                if (r_hi_y < i_cmd.item.y_low) n_hi_y = i_cmd.item.y_low;
            end
            OP_RECEPTOR: begin
                n_rec_total = sat_add(r_rec_total, COUNT_BITS'(1));
                if (r_lo_x > i_cmd.item.x_low) n_lo_x = i_cmd.item.x_low;
                if (r_hi_x < i_cmd.item.x_low) n_hi_x = i_cmd.item.x_low;
                if (r_lo_y > i_cmd.item.y_low) n_lo_y = i_cmd.item.y_low;
                if (r_hi_y < i_cmd.item.y_low) n_hi_y = i_cmd.item.y_low;
                if (r_lo_rho > i_cmd.item.rho_low) n_lo_rho = i_cmd.item.rho_low;
                if (r_hi_rho < i_cmd.item.rho_low) n_hi_rho = i_cmd.item.rho_low;
                n_lo_theta = th_rec.lo;
                n_hi_theta = th_rec.hi;
            end
            OP_MERGE: begin
                if (merge_ok) begin
                    n_absorbed  = 1'b1;
                    n_rec_total = sat_add(r_rec_total, i_cmd.item.other_receptors);
                    n_pix_total = sat_add(r_pix_total, i_cmd.item.other_pixels);
                    if (r_lo_x > i_cmd.item.x_low)  n_lo_x = i_cmd.item.x_low;
                    if (r_hi_x < i_cmd.item.x_high) n_hi_x = i_cmd.item.x_high;
                    if (r_lo_y > i_cmd.item.y_low)  n_lo_y = i_cmd.item.y_low;
                    if (r_hi_y < i_cmd.item.y_high) n_hi_y = i_cmd.item.y_high;
                    if (r_cfg_recv) begin
                        if (r_lo_rho > i_cmd.item.rho_low)  n_lo_rho = i_cmd.item.rho_low;
                        if (r_hi_rho < i_cmd.item.rho_high) n_hi_rho = i_cmd.item.rho_high;
                        n_lo_theta = th_merge.lo;
                        n_hi_theta = th_merge.hi;
                        n_crown    = r_crown | i_cmd.item.other_flags[OTHER_CROWN_BIT];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.absorbed        = n_absorbed;
        res.pixel_count     = n_pix_total;
        res.receptor_count  = n_rec_total;
        res.box_min_x       = n_lo_x;
        res.box_max_x       = n_hi_x;
        res.box_min_y       = n_lo_y;
        res.box_max_y       = n_hi_y;
        res.range_min_rho   = n_lo_rho;
        res.range_max_rho   = n_hi_rho;
        res.range_min_theta = n_lo_theta;
        res.range_max_theta = n_hi_theta;
        res.crown_flag      = n_crown;
    end

    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_obuf[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_recv  <= 1'b1;
            r_cfg_pos   <= 17'sd32768;
            r_cfg_neg   <= -17'sd32768;
            r_pix_total <= '0;
            r_rec_total <= '0;
            r_lo_x      <= '1;
            r_hi_x      <= '0;
            r_lo_y      <= '1;
            r_hi_y      <= '0;
            r_lo_rho    <= '1;
            r_hi_rho    <= '0;
            r_lo_theta  <= '0;
            r_hi_theta  <= '0;
            r_crown     <= 1'b0;
            r_alive     <= 1'b1;
            r_owp       <= '0;
            r_orp       <= '0;
            r_ocnt      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IDX_RECEPTOR: r_cfg_recv <= i_cfg_data[0];
                    CFG_IDX_WRAP_POS: r_cfg_pos  <= $signed(i_cfg_data);
                    CFG_IDX_WRAP_NEG: r_cfg_neg  <= $signed(i_cfg_data);
                    default: begin
                    end
                endcase
            end
            if (cmd_fire) begin
                r_pix_total <= n_pix_total;
                r_rec_total <= n_rec_total;
                r_lo_x      <= n_lo_x;
                r_hi_x      <= n_hi_x;
                r_lo_y      <= n_lo_y;
                r_hi_y      <= n_hi_y;
                r_lo_rho    <= n_lo_rho;
                r_hi_rho    <= n_hi_rho;
                r_lo_theta  <= n_lo_theta;
                r_hi_theta  <= n_hi_theta;
                r_crown     <= n_crown;
                r_owp       <= r_owp + OPTR_BITS'(1);
            end
            if (pop_fire) begin
                r_orp <= r_orp + OPTR_BITS'(1);
            end
            if (cmd_fire && !pop_fire) begin
                r_ocnt <= r_ocnt + OCNT_BITS'(1);
            end else if (pop_fire && !cmd_fire) begin
                r_ocnt <= r_ocnt - OCNT_BITS'(1);
            end
        end
    end

    `BEA_ASSERT_NEXT(a_rec_mono, i_clk, i_rst_n, 1'b1,
                     r_rec_total >= $past(r_rec_total))
    `BEA_ASSERT_NEXT(a_pix_step, i_clk, i_rst_n, cmd_fire && i_cmd.op == OP_PIXEL,
                     r_pix_total != $past(r_pix_total) || (&r_pix_total))
    `BEA_ASSERT_NEXT(a_none_hold, i_clk, i_rst_n, cmd_fire && i_cmd.op == OP_NONE,
                     $stable(r_pix_total) && $stable(r_rec_total) && $stable(r_lo_theta))

endmodule

`default_nettype wire

// ----- rtl/blob_extent_accumulator.sv -----
// Top level of the blob extent accumulator.
// One blob's statistics (counts, X/Y box, rho range, wrapping theta range, crown
// flag) are updated by a stream of pixel, receptor and merge transactions, one
// per clock. Each accepted transaction yields one result holding the blob state
// after the update; the result passes the front register, the command queue and
// the result buffer on its way out. The combinational update in the back end
// sets the sustained rate of one transaction per cycle; a four-entry command
// queue and a two-entry result buffer let either side stall. Configuration
// writes are taken every cycle and belong only to idle periods.
`default_nettype none

module blob_extent_accumulator (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire bea_pkg::t_item   i_item,
    output logic                  empty,
    input  wire logic             pop,
    output bea_pkg::t_result      o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [16:0]      i_cfg_data
);
    import bea_pkg::*;

    logic f_valid, f_ready;
    t_cmd f_cmd;
    logic q_valid, q_ready;
    t_cmd q_cmd;

    bea_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cmd   (f_cmd)
    );

    bea_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    bea_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_cmd       (q_cmd),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for blob_extent_accumulator: directed table, bursty random traffic.
module tb_top;
    import bea_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int N_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int MAX_SHOWN = 40;
    localparam int LIMIT_NS = 2_000_000;
    localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

    typedef struct {
        t_item   item;
        bit      literal;
        t_result res;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    t_item            i_item;
    logic             empty;
    logic             pop;
    t_result          o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index;
    logic [16:0]      i_cfg_data;

    bit               check_literal;
    t_result          literal_result;

    bit                    cfg_recv;
    int                    wrap_pos;
    int                    wrap_neg;
    logic [COUNT_BITS-1:0] pix_cnt;
    logic [COUNT_BITS-1:0] rec_cnt;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_y;
    logic [15:0]           min_rho;
    logic [15:0]           max_rho;
    int                    min_th;
    int                    max_th;
    bit                    crown;
    bit                    alive;

    t_result pending_results[$];
    t_row    table_rows[$];
    t_result predicted;
    t_result wanted;

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_pix = 0;
    int n_rec = 0;
    int n_abs = 0;
    int n_idle = 0;
    int n_settings = 0;
    int burst_left = 8;
    int rx_mode = 0;
    int rx_left = 0;
    int rx_cyc = 0;

    blob_extent_accumulator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("** blob_extent_accumulator: FAILED **");
        $finish;
    end

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? COUNT_SAT : s[COUNT_BITS-1:0];
    endfunction

    function automatic int mag(input int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void widen_box(input logic [COORD_BITS-1:0] xl, xh, yl, yh);
        if (min_x > xl) min_x = xl;
        if (max_x < xh) max_x = xh;
        if (min_y > yl) min_y = yl;
        if (max_y < yh) max_y = yh;
    endfunction

    function automatic void add_theta(input int t);
        if (min_th > max_th) begin
            if (mag(min_th - t) < mag(max_th - t)) begin
                if (min_th > t) min_th = t;
            end else begin
                if (max_th < t) max_th = t;
            end
        end else if ((max_th - t) > wrap_pos || (min_th - t) > wrap_pos) begin
            max_th = t;
        end else if ((max_th - t) < wrap_neg || (min_th - t) < wrap_neg) begin
            min_th = t;
        end else begin
            if (min_th > t) min_th = t;
            if (max_th < t) max_th = t;
        end
    endfunction

    function automatic void merge_theta(input int bmin, input int bmax);
        bit self_wrap;
        bit other_wrap;
        self_wrap = min_th > max_th;
        other_wrap = bmin > bmax;
        if (self_wrap && other_wrap) begin
            if (min_th > bmin) min_th = bmin;
            if (max_th < bmax) max_th = bmax;
        end else if (self_wrap) begin
            if ((min_th - bmin) > wrap_pos) begin
                if (max_th < bmax) max_th = bmax;
            end else if ((max_th - bmax) < wrap_neg) begin
                if (min_th > bmin) min_th = bmin;
            end else begin
                if (min_th > bmin) min_th = bmin;
                if (max_th < bmax) max_th = bmax;
            end
        end else if (other_wrap) begin
            if ((min_th - bmin) < wrap_neg) begin
                if (min_th < bmin) min_th = bmin;
                if (max_th < bmax) max_th = bmax;
            end else if ((max_th - bmax) > wrap_pos) begin
                if (min_th > bmin) min_th = bmin;
                if (max_th > bmax) max_th = bmax;
            end else begin
                if (min_th > bmin) min_th = bmin;
                if (max_th < bmax) max_th = bmax;
            end
        end else if ((max_th - bmax) > wrap_pos || (min_th - bmin) > wrap_pos) begin
            max_th = bmax;
        end else if ((max_th - bmax) < wrap_neg || (min_th - bmax) < wrap_neg) begin
            min_th = bmin;
        end else begin
            if (min_th > bmin) min_th = bmin;
            if (max_th < bmax) max_th = bmax;
        end
    endfunction

    function automatic t_result blob_update(input t_item it);
        t_result r;
        int      tl;
        int      th;
        bit      absorbed;
        tl = it.theta_low;
        th = it.theta_high;
        absorbed = 1'b0;
        case (it.func)
            FUNC_PIXEL: begin
                pix_cnt = sat_add(pix_cnt, COUNT_BITS'(1));
                widen_box(it.x_low, it.x_low, it.y_low, it.y_low);
            end
            FUNC_RECEPTOR: begin
                rec_cnt = sat_add(rec_cnt, COUNT_BITS'(1));
                widen_box(it.x_low, it.x_low, it.y_low, it.y_low);
                if (min_rho > it.rho_low) min_rho = it.rho_low;
                if (max_rho < it.rho_low) max_rho = it.rho_low;
                add_theta(tl);
            end
            FUNC_MERGE: begin
                if (alive && it.other_flags[OTHER_VALID_BIT]) begin
                    absorbed = 1'b1;
                    rec_cnt = sat_add(rec_cnt, it.other_receptors);
                    pix_cnt = sat_add(pix_cnt, it.other_pixels);
                    widen_box(it.x_low, it.x_high, it.y_low, it.y_high);
                    if (cfg_recv) begin
                        if (min_rho > it.rho_low) min_rho = it.rho_low;
                        if (max_rho < it.rho_high) max_rho = it.rho_high;
                        merge_theta(tl, th);
                        crown = crown | it.other_flags[OTHER_CROWN_BIT];
                    end
                end
            end
            default: ;
        endcase
        r.absorbed        = absorbed;
        r.pixel_count     = pix_cnt;
        r.receptor_count  = rec_cnt;
        r.box_min_x       = min_x;
        r.box_max_x       = max_x;
        r.box_min_y       = min_y;
        r.box_max_y       = max_y;
        r.range_min_rho   = min_rho;
        r.range_max_rho   = max_rho;
        r.range_min_theta = min_th[15:0];
        r.range_max_theta = max_th[15:0];
        r.crown_flag      = crown;
        return r;
    endfunction

    function automatic t_item mk_item(input int func, xl, xh, yl, yh, rl, rh, tl, th,
                                      orec, opix, flags);
        t_item it;
        it.func            = func[1:0];
        it.x_low           = xl[COORD_BITS-1:0];
        it.x_high          = xh[COORD_BITS-1:0];
        it.y_low           = yl[COORD_BITS-1:0];
        it.y_high          = yh[COORD_BITS-1:0];
        it.rho_low         = rl[15:0];
        it.rho_high        = rh[15:0];
        it.theta_low       = tl[15:0];
        it.theta_high      = th[15:0];
        it.other_receptors = orec[COUNT_BITS-1:0];
        it.other_pixels    = opix[COUNT_BITS-1:0];
        it.other_flags     = flags[1:0];
        return it;
    endfunction

    function automatic t_result mk_res(input int absorbed, pix, rec, mnx, mxx, mny, mxy,
                                       mnr, mxr, mnt, mxt, crw);
        t_result r;
        r.absorbed        = absorbed[0];
        r.pixel_count     = pix[COUNT_BITS-1:0];
        r.receptor_count  = rec[COUNT_BITS-1:0];
        r.box_min_x       = mnx[COORD_BITS-1:0];
        r.box_max_x       = mxx[COORD_BITS-1:0];
        r.box_min_y       = mny[COORD_BITS-1:0];
        r.box_max_y       = mxy[COORD_BITS-1:0];
        r.range_min_rho   = mnr[15:0];
        r.range_max_rho   = mxr[15:0];
        r.range_min_theta = mnt[15:0];
        r.range_max_theta = mxt[15:0];
        r.crown_flag      = crw[0];
        return r;
    endfunction

    function automatic logic [15:0] rand_theta();
        int v;
        case ($urandom_range(3, 0))
            0:       v = $urandom_range(65535, 0);
            1:       v = 32767 - $urandom_range(400, 0);
            2:       v = -32768 + $urandom_range(400, 0);
            default: v = $urandom_range(600, 0) - 300;
        endcase
        return v[15:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord(input int spread, input bit big);
        int v;
        if (big)
            v = ($urandom_range(3, 0) == 0) ? ($urandom_range(1, 0) ? 1023 : 0)
                                            : $urandom_range(1023, 0);
        else
            v = 512 - spread + $urandom_range(2 * spread, 0);
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic [15:0] rand_rho(input int spread, input bit big);
        int v;
        if (big)
            v = ($urandom_range(3, 0) == 0) ? ($urandom_range(1, 0) ? 65535 : 0)
                                            : $urandom_range(65535, 0);
        else
            v = 32768 - spread + $urandom_range(2 * spread, 0);
        return v[15:0];
    endfunction

    function automatic t_item gen_item(input int k, input bit big, output bit counted);
        logic [159:0] noise;
        t_item        it;
        int           pick;
        int           sp;
        int           spr;
        noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        it = noise[$bits(t_item)-1:0];
        sp = (k / 4 + 4 > 511) ? 511 : k / 4 + 4;
        spr = (64 + k * 16 > 32767) ? 32767 : 64 + k * 16;
        pick = $urandom_range(99, 0);
        counted = 1'b1;
        if (pick < 35) begin
            it.func  = FUNC_PIXEL;
            it.x_low = rand_coord(sp, big);
            it.y_low = rand_coord(sp, big);
        end else if (pick < 70) begin
            it.func      = FUNC_RECEPTOR;
            it.x_low     = rand_coord(sp, big);
            it.y_low     = rand_coord(sp, big);
            it.rho_low   = rand_rho(spr, big);
            it.theta_low = rand_theta();
        end else if (pick < 90) begin
            it.func            = FUNC_MERGE;
            it.x_low           = rand_coord(sp, big);
            it.x_high          = rand_coord(sp, big);
            it.y_low           = rand_coord(sp, big);
            it.y_high          = rand_coord(sp, big);
            it.rho_low         = rand_rho(spr, big);
            it.rho_high        = rand_rho(spr, big);
            it.theta_low       = rand_theta();
            it.theta_high      = rand_theta();
            it.other_receptors = big ? COUNT_BITS'($urandom_range(1048575, 0))
                                     : COUNT_BITS'($urandom_range(7, 0));
            it.other_pixels    = big ? COUNT_BITS'($urandom_range(1048575, 0))
                                     : COUNT_BITS'($urandom_range(7, 0));
            it.other_flags[OTHER_VALID_BIT] = 1'b1;
        end else begin
            counted = 1'b0;
            if (it.func != FUNC_UNUSED) begin
                it.func = FUNC_MERGE;
                it.other_flags[OTHER_VALID_BIT] = 1'b0;
            end
        end
        return it;
    endfunction

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic compare_result(input t_result got, input t_result want);
        check_field("absorbed", got.absorbed, want.absorbed);
        check_field("pixel_count", got.pixel_count, want.pixel_count);
        check_field("receptor_count", got.receptor_count, want.receptor_count);
        check_field("box_min_x", got.box_min_x, want.box_min_x);
        check_field("box_max_x", got.box_max_x, want.box_max_x);
        check_field("box_min_y", got.box_min_y, want.box_min_y);
        check_field("box_max_y", got.box_max_y, want.box_max_y);
        check_field("range_min_rho", got.range_min_rho, want.range_min_rho);
        check_field("range_max_rho", got.range_max_rho, want.range_max_rho);
        check_field("range_min_theta", got.range_min_theta, want.range_min_theta);
        check_field("range_max_theta", got.range_max_theta, want.range_max_theta);
        check_field("crown_flag", got.crown_flag, want.crown_flag);
    endtask

    task automatic send_item(input t_item it, input bit literal, input t_result res);
        push <= 1'b1;
        i_item <= it;
        check_literal <= literal;
        literal_result <= res;
        do @(posedge i_clk); while (full);
        n_sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic pace();
        burst_left--;
        if (burst_left <= 0) begin
            idle_gap(($urandom_range(4, 0) == 0) ? $urandom_range(30, 1) : $urandom_range(5, 1));
            burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(120, 60)
                                                     : $urandom_range(12, 1);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (n_checked < n_sent) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [16:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IDX_RECEPTOR: cfg_recv = data[0];
            CFG_IDX_WRAP_POS: wrap_pos = $signed(data);
            CFG_IDX_WRAP_NEG: wrap_neg = $signed(data);
            default: ;
        endcase
    endtask

    task automatic set_config(input bit recv, input int pos, input int neg);
        wait_idle();
        cfg_write(CFG_IDX_RECEPTOR, {16'd0, recv});
        cfg_write(CFG_IDX_WRAP_POS, pos[16:0]);
        cfg_write(CFG_IDX_WRAP_NEG, neg[16:0]);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(3, 0);
                rx_left <= $urandom_range(256, 32);
            end else begin
                rx_left <= rx_left - 1;
            end
            rx_cyc <= rx_cyc + 1;
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(1, 0));
                2:       pop <= (rx_cyc % 7) >= 3;
                default: pop <= ($urandom_range(15, 0) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            predicted = blob_update(i_item);
            pending_results.push_back(check_literal ? literal_result : predicted);
            case (i_item.func)
                FUNC_PIXEL:    n_pix++;
                FUNC_RECEPTOR: n_rec++;
                default: begin
                    if (predicted.absorbed) n_abs++;
                    else n_idle++;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_error("result transaction with nothing pending");
            end else begin
                wanted = pending_results.pop_front();
                compare_result(o_result, wanted);
            end
            n_checked++;
        end
    end

    initial begin
        t_item it;
        t_result reset_res;
        bit counted;
        bit recv;
        int pos;
        int neg;
        int done;
        int k;
        bit phase_recv [N_PHASES];
        int phase_pos [N_PHASES];
        int phase_neg [N_PHASES];

        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        check_literal = 1'b0;
        literal_result = '0;
        cfg_recv = 1'b1;
        wrap_pos = 32768;
        wrap_neg = -32768;
        pix_cnt = '0;
        rec_cnt = '0;
        min_x = '1;
        max_x = '0;
        min_y = '1;
        max_y = '0;
        min_rho = '1;
        max_rho = '0;
        min_th = 0;
        max_th = 0;
        crown = 1'b0;
        alive = 1'b1;
        phase_recv = '{1, 0, 1, 1, 1, 1, 1, 1};
        phase_pos = '{32768, 32768, 65535, -65535, 16384, 0, 0, 32768};
        phase_neg = '{-32768, -32768, -65535, 65535, -16384, 0, 0, -32768};

        reset_res = mk_res(0, 0, 0, 1023, 0, 1023, 0, 65535, 0, 0, 0, 0);
        table_rows.push_back('{mk_item(FUNC_UNUSED, 1023, 1023, 1023, 1023, 65535, 65535,
                                       -32768, 32767, 1048575, 1048575, 3), 1'b1, reset_res});
        table_rows.push_back('{mk_item(FUNC_MERGE, 0, 1023, 0, 1023, 0, 65535,
                                       32767, -32768, 1048575, 1048575, 2), 1'b1, reset_res});
        table_rows.push_back('{mk_item(FUNC_PIXEL, 512, 0, 300, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               mk_res(0, 1, 0, 512, 512, 300, 300, 65535, 0, 0, 0, 0)});
        table_rows.push_back('{mk_item(FUNC_RECEPTOR, 520, 0, 310, 0, 1000, 0, 0, 0, 0, 0, 0),
                               1'b1, mk_res(0, 1, 1, 512, 520, 300, 310, 1000, 1000, 0, 0, 0)});
        table_rows.push_back('{mk_item(FUNC_RECEPTOR, 515, 0, 305, 0, 900, 0, 32767, 0,
                                       0, 0, 0), 1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_RECEPTOR, 515, 0, 305, 0, 1100, 0, -32768, 0,
                                       0, 0, 0), 1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_RECEPTOR, 516, 0, 306, 0, 1000, 0, 100, 0,
                                       0, 0, 0), 1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_RECEPTOR, 514, 0, 304, 0, 1000, 0, -200, 0,
                                       0, 0, 0), 1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_PIXEL, 400, 0, 250, 0, 0, 0, 0, 0, 0, 0, 0),
                               1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_MERGE, 450, 600, 280, 320, 950, 1200, 1000, -1000,
                                       3, 5, 1), 1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_MERGE, 460, 580, 290, 330, 800, 1300, -500, 500,
                                       2, 2, 3), 1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                               1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_MERGE, 100, 900, 100, 900, 10, 60000, 0, 0,
                                       9, 9, 2), 1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_RECEPTOR, 517, 0, 307, 0, 1000, 0, 16000, 0,
                                       0, 0, 0), 1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_MERGE, 470, 560, 295, 315, 990, 1010, 20000,
                                       30000, 1, 1, 1), 1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_PIXEL, 513, 0, 301, 0, 0, 0, 0, 0, 0, 0, 0),
                               1'b0, '0});
        table_rows.push_back('{mk_item(FUNC_RECEPTOR, 518, 0, 308, 0, 1005, 0, -32000, 0,
                                       0, 0, 0), 1'b0, '0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) begin
            send_item(table_rows[i].item, table_rows[i].literal, table_rows[i].res);
            pace();
        end

        k = 0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            recv = phase_recv[ph];
            pos = phase_pos[ph];
            neg = phase_neg[ph];
            if (ph == 6) begin
                recv = 1'($urandom_range(1, 0));
                pos = $urandom_range(131070, 0) - 65535;
                neg = $urandom_range(131070, 0) - 65535;
            end
            set_config(recv, pos, neg);
            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                it = gen_item(k, ph == N_PHASES - 1, counted);
                send_item(it, 1'b0, '0);
                pace();
                if (counted) begin
                    done++;
                    k++;
                end
            end
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        if (!empty)
            report_error("result left waiting with nothing pending");

        $display("Run covered %0d transactions: %0d pixels, %0d receptors, %0d absorbed blobs,",
                 n_sent, n_pix, n_rec, n_abs);
        $display("%0d left the blob unchanged, over %0d register settings; %0d results checked.",
                 n_idle, n_settings, n_checked);
        if (n_errors == 0) begin
            $display("** blob_extent_accumulator: PASSED **");
        end else begin
            $display("** blob_extent_accumulator: FAILED **");
        end
        $finish;
    end

endmodule
